// File: sv/stbs_pkg.sv
// shared types and constants of the string table bubble sorter
package stbs_pkg;

	localparam int MAX_STRINGS_DEF = 16;
	localparam int MAX_LEN_DEF     = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPW             = $clog2(QUEUE_DEPTH);
	localparam int IDX_W           = 4;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_TERM,
		KIND_END
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] string_index;
		logic             last_in_order;
		logic             table_empty;
		logic             truncated;
	} result_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_INIT,
		ST_PS,
		ST_PS2,
		ST_NXT,
		ST_BRD,
		ST_BEV,
		ST_WR,
		ST_WL,
		ST_ERD,
		ST_EOUT,
		ST_EMPTY
	} state_t;

endpackage

// File: sv/stbs_front.sv
// input side: classifies stream transactions and queues them for the sorter
module stbs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // char_byte
	input  logic              s_tuser,   // table_end
	output stbs_pkg::item_t   q_item,
	output logic              q_valid,
	input  logic              q_ready
);
	import stbs_pkg::*;

	item_t          fifo_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QPW:0]   count_q;
	item_t          in_item;
	logic           push;
	logic           pop;

	// classify the incoming transaction
	always_comb begin
		in_item.data = s_tdata;
		if (s_tuser) begin
			in_item.kind = KIND_END;
		end else if (s_tdata == 8'd0) begin
			in_item.kind = KIND_TERM;
		end else begin
			in_item.kind = KIND_BYTE;
		end
	end

	assign s_tready = (count_q != (QPW+1)'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_item   = fifo_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPW+1)'(1);
			end
		end
	end

endmodule

// File: sv/stbs_engine.sv
// back side: string store, bubble sort over the order table, result output
module stbs_engine #(
	parameter int MAX_STRINGS = stbs_pkg::MAX_STRINGS_DEF,
	parameter int MAX_LEN     = stbs_pkg::MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  stbs_pkg::item_t   q_item,
	input  logic              q_valid,
	output logic              q_ready,
	output stbs_pkg::result_t res,
	output logic              res_valid,
	input  logic              res_ready
);
	import stbs_pkg::*;

	localparam int SW    = $clog2(MAX_STRINGS);
	localparam int CW    = $clog2(MAX_STRINGS + 1);
	localparam int BW    = $clog2(MAX_LEN + 1);
	localparam int DEPTH = MAX_STRINGS * MAX_LEN;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [BW-1:0] bp_q;
	logic          ovf_q;
	logic [CW-1:0] n_q;
	logic          trunc_q;
	logic [SW-1:0] lim_q, j_q, cur_q, nxt_q, e_q;
	logic [BW-1:0] k_q;
	logic          gt_q;

	logic [7:0]    store_mem [DEPTH];
	logic [7:0]    a_q, b_q;
	logic [SW-1:0] ord_mem [MAX_STRINGS];
	logic [SW-1:0] ord_rd_q;

	logic          st_we;
	logic [AW-1:0] st_waddr, st_ra, st_rb;
	logic [7:0]    st_wdata;
	logic          ord_we;
	logic [SW-1:0] ord_waddr, ord_wdata, ord_raddr;

	result_t       res_q;
	logic          res_valid_q;
	logic          slot_free;
	logic          pop;
	logic          cnt_full, bp_full, bp_nz, cnt_bump;
	logic [CW-1:0] n_d;
	logic          last_cmp, byte_diff, byte_stop;

	assign cnt_full  = (cnt_q == CW'(MAX_STRINGS));
	assign bp_full   = (bp_q == BW'(MAX_LEN));
	assign bp_nz     = (bp_q != '0);
	assign pop       = q_valid && q_ready;
	assign cnt_bump  = bp_nz && !cnt_full;
	assign n_d       = cnt_q + CW'(cnt_bump);
	assign slot_free = !res_valid_q || res_ready;
	assign last_cmp  = (({1'b0, j_q} + (SW+1)'(1)) == {1'b0, lim_q});
	assign byte_diff = (a_q != b_q);
	assign byte_stop = (a_q == 8'd0) || (k_q == BW'(MAX_LEN - 1));
	assign res       = res_q;
	assign res_valid = res_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (pop && q_item.kind == KIND_END) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				if (n_q == '0) begin
					state_d = ST_EMPTY;
				end else if (j_q == SW'(n_q - CW'(1))) begin
					state_d = (lim_q == '0) ? ST_ERD : ST_PS;
				end
			end
			ST_PS:  state_d = ST_PS2;
			ST_PS2: state_d = ST_NXT;
			ST_NXT: state_d = ST_BRD;
			ST_BRD: state_d = ST_BEV;
			ST_BEV: begin
				state_d = (byte_diff || byte_stop) ? ST_WR : ST_BRD;
			end
			ST_WR: state_d = last_cmp ? ST_WL : ST_NXT;
			ST_WL: state_d = (lim_q == SW'(1)) ? ST_ERD : ST_PS;
			ST_ERD: state_d = ST_EOUT;
			ST_EOUT: begin
				if (slot_free) begin
					state_d = (e_q == SW'(n_q - CW'(1))) ? ST_LOAD : ST_ERD;
				end
			end
			ST_EMPTY: begin
				if (slot_free) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// memory controls
	always_comb begin
		q_ready   = (state_q == ST_LOAD);
		st_we     = 1'b0;
		st_wdata  = 8'd0;
		st_waddr  = AW'(AW'(SW'(cnt_q)) * MAX_LEN) + AW'(bp_q);
		st_ra     = AW'(AW'(cur_q) * MAX_LEN) + AW'(k_q);
		st_rb     = AW'(AW'(nxt_q) * MAX_LEN) + AW'(k_q);
		ord_we    = 1'b0;
		ord_waddr = j_q;
		ord_wdata = j_q;
		ord_raddr = e_q;
		unique case (state_q)
			ST_LOAD: begin
				if (pop && !cnt_full && !bp_full) begin
					if (q_item.kind == KIND_BYTE) begin
						st_we    = 1'b1;
						st_wdata = q_item.data;
					end else if (q_item.kind == KIND_TERM || bp_nz) begin
						st_we = 1'b1;
					end
				end
			end
			ST_INIT: ord_we = (n_q != '0);
			ST_PS:   ord_raddr = '0;
			ST_PS2:  ord_raddr = SW'(1);
			ST_WR: begin
				ord_we    = 1'b1;
				ord_wdata = gt_q ? nxt_q : cur_q;
				ord_raddr = SW'({1'b0, j_q} + (SW+1)'(2));
			end
			ST_WL: begin
				ord_we    = 1'b1;
				ord_waddr = lim_q;
				ord_wdata = cur_q;
			end
			default: begin
			end
		endcase
	end

	// string store with two registered read ports
	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_waddr] <= st_wdata;
		end
		a_q <= store_mem[st_ra];
		b_q <= store_mem[st_rb];
	end

	// order table
	always_ff @(posedge clk) begin
		if (ord_we) begin
			ord_mem[ord_waddr] <= ord_wdata;
		end
		ord_rd_q <= ord_mem[ord_raddr];
	end

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			bp_q        <= '0;
			ovf_q       <= 1'b0;
			n_q         <= '0;
			trunc_q     <= 1'b0;
			lim_q       <= '0;
			j_q         <= '0;
			k_q         <= '0;
			cur_q       <= '0;
			nxt_q       <= '0;
			gt_q        <= 1'b0;
			e_q         <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (pop) begin
						unique case (q_item.kind)
							KIND_BYTE: begin
								if (cnt_full || bp_full) begin
									ovf_q <= 1'b1;
								end else begin
									bp_q <= bp_q + BW'(1);
								end
							end
							KIND_TERM: begin
								if (cnt_full) begin
									ovf_q <= 1'b1;
								end else begin
									cnt_q <= cnt_q + CW'(1);
								end
								bp_q <= '0;
							end
							KIND_END: begin
								n_q     <= n_d;
								trunc_q <= ovf_q || (bp_nz && cnt_full);
								lim_q   <= SW'(n_d - CW'(1));
								j_q     <= '0;
								cnt_q   <= '0;
								bp_q    <= '0;
								ovf_q   <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_INIT: begin
					j_q <= j_q + SW'(1);
					e_q <= '0;
				end
				ST_PS2: begin
					cur_q <= ord_rd_q;
					j_q   <= '0;
				end
				ST_NXT: begin
					nxt_q <= ord_rd_q;
					k_q   <= '0;
				end
				ST_BEV: begin
					if (byte_diff) begin
						gt_q <= (a_q > b_q);
					end else if (byte_stop) begin
						gt_q <= 1'b0;
					end else begin
						k_q <= k_q + BW'(1);
					end
				end
				ST_WR: begin
					if (!gt_q) begin
						cur_q <= nxt_q;
					end
					j_q <= j_q + SW'(1);
				end
				ST_WL: begin
					lim_q <= lim_q - SW'(1);
					e_q   <= '0;
				end
				ST_EOUT: begin
					if (slot_free) begin
						res_q.string_index  <= IDX_W'(ord_rd_q);
						res_q.last_in_order <= (e_q == SW'(n_q - CW'(1)));
						res_q.table_empty   <= 1'b0;
						res_q.truncated     <= trunc_q;
						res_valid_q         <= 1'b1;
						e_q                 <= e_q + SW'(1);
					end
				end
				ST_EMPTY: begin
					if (slot_free) begin
						res_q.string_index  <= '0;
						res_q.last_in_order <= 1'b1;
						res_q.table_empty   <= 1'b1;
						res_q.truncated     <= trunc_q;
						res_valid_q         <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: sv/string_table_bubble_sort.sv
// top level of the string table bubble sorter
// Bytes of a string table arrive one per cycle, when the four-entry queue has room,
// and are written into the string store; a zero byte closes a string and a
// transaction with tuser set closes the table. The sorter then stops taking bytes
// from the queue and runs a bubble sort over the order table: it first fills the
// order table, one entry per string; each neighbor comparison reads the next entry,
// reads both strings a byte at a time from the two-port store, compares them and
// writes the smaller entry back; there are about n*(n-1)/2 comparisons for n strings.
// Sorted indices leave one by one via an output register; then the next table loads.
module string_table_bubble_sort #(
	parameter int MAX_STRINGS = stbs_pkg::MAX_STRINGS_DEF,
	parameter int MAX_LEN     = stbs_pkg::MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // char_byte
	input  logic       s_tuser,   // table_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // string_index, zero fill
	output logic       m_tlast,   // last_in_order
	output logic [1:0] m_tuser    // table_empty, truncated
);
	import stbs_pkg::*;

	item_t   q_item;
	logic    q_valid;
	logic    q_ready;
	result_t res;

	stbs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_item   (q_item),
		.q_valid  (q_valid),
		.q_ready  (q_ready)
	);

	stbs_engine #(
		.MAX_STRINGS (MAX_STRINGS),
		.MAX_LEN     (MAX_LEN)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_item    (q_item),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.res       (res),
		.res_valid (m_tvalid),
		.res_ready (m_tready)
	);

	// result packing
	assign m_tdata = {(8 - IDX_W)'(0), res.string_index};
	assign m_tlast = res.last_in_order;
	assign m_tuser = {res.truncated, res.table_empty};

	// an empty table gives a single closing result
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast) else $error("empty result not last");

	// an empty table reports index zero
	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 8'd0) else $error("empty result index");

	// a stalled result holds still
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser)) else $error("result changed while stalled");

endmodule

// File: tb/string_table_bubble_sort_tb.sv
// testbench of the string table bubble sorter: directed and random tables checked by a predictor
`timescale 1ns / 1ps

module string_table_bubble_sort_tb;
	import stbs_pkg::*;

	localparam int NSTR = MAX_STRINGS_DEF;
	localparam int NLEN = MAX_LEN_DEF;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [1:0] m_tuser;

	// predictor state
	logic [7:0] text_mem [NSTR][NLEN];
	int         text_len [NSTR];
	int         str_cnt;
	int         byte_pos;
	bit         trunc_seen;

	result_t    sorted_q[$];
	int         mismatches;
	int         send_idle_pct;
	int         recv_stall_pct;
	bit         hold_off;

	string_table_bubble_sort dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	// true when string a sorts strictly after string b
	function automatic bit str_greater(int a, int b);
		int ca;
		int cb;
		for (int k = 0; k < NLEN; k++) begin
			ca = (k < text_len[a]) ? text_mem[a][k] : 0;
			cb = (k < text_len[b]) ? text_mem[b][k] : 0;
			if (ca != cb) return ca > cb;
			if (ca == 0) return 0;
		end
		return 0;
	endfunction

	task automatic close_string();
		if (str_cnt < NSTR) begin
			text_len[str_cnt] = byte_pos;
			str_cnt++;
		end else begin
			trunc_seen = 1;
		end
		byte_pos = 0;
	endtask

	// update the predictor with one accepted transaction
	task automatic predict_sort(input logic [7:0] ch, input logic fin);
		int      order [NSTR];
		int      n;
		int      t;
		result_t r;
		if (!fin) begin
			if (ch == 0) close_string();
			else if (str_cnt >= NSTR || byte_pos >= NLEN) trunc_seen = 1;
			else begin
				text_mem[str_cnt][byte_pos] = ch;
				byte_pos++;
			end
			return;
		end
		if (byte_pos != 0) close_string();
		n = str_cnt;
		if (n == 0) begin
			r.string_index = '0;
			r.last_in_order = 1;
			r.table_empty = 1;
			r.truncated = trunc_seen;
			sorted_q.push_back(r);
		end else begin
			for (int i = 0; i < n; i++) order[i] = i;
			for (int i = 0; i + 1 < n; i++)
				for (int j = 0; j + 1 < n - i; j++)
					if (str_greater(order[j], order[j + 1])) begin
						t = order[j];
						order[j] = order[j + 1];
						order[j + 1] = t;
					end
			for (int i = 0; i < n; i++) begin
				r.string_index = order[i][IDX_W-1:0];
				r.last_in_order = (i + 1 == n);
				r.table_empty = 0;
				r.truncated = trunc_seen;
				sorted_q.push_back(r);
			end
		end
		str_cnt = 0;
		byte_pos = 0;
		trunc_seen = 0;
	endtask

	// send one transaction, waiting for the handshake
	task automatic send_item(input logic [7:0] ch, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= ch;
		s_tuser <= fin;
		do @(posedge clk); while (!s_tready);
		predict_sort(ch, fin);
	endtask

	task automatic send_string(input string s, input bit term);
		for (int i = 0; i < s.len(); i++) send_item(s[i], 0);
		if (term) send_item(8'h00, 0);
	endtask

	task automatic send_rand_string(input int maxlen, output int nsent);
		int len;
		len = $urandom_range(maxlen);
		for (int i = 0; i < len; i++)
			// narrow alphabet so many strings share prefixes
			send_item($urandom_range(3) == 0 ? 8'($urandom_range(1, 255))
				: 8'($urandom_range(8'h61, 8'h63)), 0);
		send_item(8'h00, 0);
		nsent = len + 1;
	endtask

	// receiver ready with random stalls, and a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// compare each result against the oldest expectation
	always @(posedge clk) begin
		result_t r;
		if (arst_n && m_tvalid && m_tready) begin
			if (sorted_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", m_tdata);
			end else begin
				r = sorted_q.pop_front();
				if (m_tdata != {4'b0, r.string_index} || m_tlast != r.last_in_order
					|| m_tuser[0] != r.table_empty || m_tuser[1] != r.truncated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("exp idx %0d last %b empty %b trunc %b, got %h %b %b",
							r.string_index, r.last_in_order, r.table_empty, r.truncated,
							m_tdata, m_tlast, m_tuser);
				end
			end
		end
	end

	task automatic drain();
		while (sorted_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		// empty table, then empty strings
		send_item(8'h41, 1);
		send_item(8'h00, 0);
		send_item(8'h00, 0);
		send_item(8'h00, 1);
		// extreme bytes, equal strings, unterminated last string
		send_string("\xff\x01", 1);
		send_item(8'h01, 0);
		send_item(8'h00, 0);
		send_item(8'hff, 0);
		send_item(8'h01, 1);
		send_string("ab", 1);
		send_string("ab", 1);
		send_string("a", 0);
		send_item(8'h00, 1);
	endtask

	task automatic test_overflow();
		// string longer than the limit, then too many strings in one table
		send_string("zzzzzzzzzzzzzzzzzzy", 1);
		send_string("zzzzzzzzzzzzzzzzx", 1);
		send_item(8'h00, 1);
		for (int i = 0; i < NSTR; i++) begin
			send_item(8'(8'h70 - i), 0);
			send_item(8'h00, 0);
		end
		send_string("q", 1);
		send_item(8'h00, 0);
		send_item(8'h00, 1);
	endtask

	task automatic test_random(input int items);
		int sent;
		int nstr;
		int cnt;
		sent = 0;
		while (sent < items) begin
			nstr = ($urandom_range(9) == 0) ? $urandom_range(NSTR + 2) : $urandom_range(6);
			for (int i = 0; i < nstr; i++) begin
				send_rand_string($urandom_range(7) == 0 ? NLEN + 2 : 4, cnt);
				sent += cnt;
			end
			send_item(8'($urandom), 1);
			sent++;
		end
	endtask

	task automatic test_backpressure();
		// receiver holds off while several tables queue up
		fork
			begin
				hold_off = 1;
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
			test_random(36);
		join
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		hold_off = 0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		str_cnt = 0;
		byte_pos = 0;
		trunc_seen = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_random(100);
		send_idle_pct = 64;
		test_random(80);
		send_idle_pct = 0;
		recv_stall_pct = 64;
		test_random(80);
		send_idle_pct = 31;
		recv_stall_pct = 31;
		test_random(80);
		test_backpressure();
		s_tvalid <= 0;
		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && sorted_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
